// ----- rtl/grover_iteration_core_assert.svh -----
// assertion macros used by the checker file
`ifndef GROVER_ITERATION_CORE_ASSERT_SVH
`define GROVER_ITERATION_CORE_ASSERT_SVH

// checked only while out of reset
`define GI_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GI_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gi_pkg.sv -----
package gi_pkg;

  // fixed field widths
  localparam int AMP_W      = 18;  // signed q1.16 amplitude
  localparam int ROOT_W     = 17;  // unsigned square root
  localparam int PROB_W     = 17;  // unsigned q1.16 probability
  localparam int REM_W      = 19;  // square root partial remainder
  localparam int RAD_W      = 34;  // radicand, probability << 16, even width
  localparam int NV_W       = 19;  // new amplitude after inversion
  localparam int MAG_W      = 18;
  localparam int PROD_W     = 36;
  localparam int TGT_W      = 3;
  localparam int SIDX_W     = 3;
  localparam int SQRT_STEPS = 17;
  localparam int SQRT_CNT_W = 5;

  localparam logic [PROB_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [TGT_W-1:0]  TARGET_RESET = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ACCUM,
    ST_RD,
    ST_NV,
    ST_MUL,
    ST_OUT
  } gi_state_t;

  typedef struct packed {
    logic load_in;
    logic sqrt_step;
    logic accum;
    logic calc_nv;
    logic calc_mul;
    logic emit_done;
  } gi_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic idx_last;
  } gi_sts_t;

endpackage

// ----- rtl/gi_ram.sv -----
module gi_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gi_ctrl.sv -----
module gi_ctrl import gi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  gi_sts_t sts,
  output logic    in_ready,
  output logic    out_valid,
  output gi_cmd_t cmd
);

  gi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SQRT;
      ST_SQRT:  if (sts.sqrt_done) state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = sts.idx_last ? ST_RD : ST_IDLE;
      ST_RD:    state_nxt = ST_NV;
      ST_NV:    state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = sts.idx_last ? ST_IDLE : ST_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_ACCUM: cmd.accum     = 1'b1;
      ST_RD:    cmd           = '0;
      ST_NV:    cmd.calc_nv   = 1'b1;
      ST_MUL:   cmd.calc_mul  = 1'b1;
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.emit_done = out_ready;
      end
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- rtl/gi_dp.sv -----
module gi_dp import gi_pkg::*; #(
  parameter int QUBITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gi_cmd_t           cmd,
  output gi_sts_t           sts,
  input  logic              cfg_wr_en,
  input  logic [TGT_W-1:0]  cfg_wr_data,
  input  logic [PROB_W-1:0] probability,
  input  logic              negative,
  output logic [SIDX_W-1:0] state_index,
  output logic [PROB_W-1:0] out_probability,
  output logic              out_negative,
  output logic              last_entry
);

  localparam int DEPTH = 1 << QUBITS;
  localparam int TOT_W = AMP_W + QUBITS;
  localparam int CMP_W = (QUBITS > TGT_W) ? QUBITS : TGT_W;

  logic [TGT_W-1:0]      target_r;
  logic [QUBITS-1:0]     idx_r;
  logic signed [TOT_W-1:0] total_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic                  neg_r;
  logic signed [NV_W-1:0] nv_r;
  logic [PROD_W-1:0]     prod_r;

  logic [PROB_W-1:0]     p_sat;
  logic [REM_W+1:0]      trial;
  logic [REM_W+1:0]      cmp_val;
  logic                  flip;
  logic [AMP_W-1:0]      amp_mag;
  logic [AMP_W-1:0]      amp;
  logic [AMP_W-1:0]      rd_amp;
  logic signed [TOT_W-1:0] twice_mean;
  logic [NV_W-1:0]       nv_nxt;
  logic [NV_W-1:0]       nv_abs;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W-16-1:0]  prob_full;

  assign p_sat   = (probability > ONE_Q16) ? ONE_Q16 : probability;
  assign trial   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign cmp_val = (REM_W+2)'({root_r, 2'b01});

  assign flip    = neg_r ^ (CMP_W'(idx_r) == CMP_W'(target_r));
  assign amp_mag = {1'b0, root_r};
  assign amp     = flip ? (AMP_W'(0) - amp_mag) : amp_mag;

  // floor(2 * total / 2^qubits) is an arithmetic shift by qubits - 1
  assign twice_mean = total_r >>> (QUBITS - 1);
  assign nv_nxt     = twice_mean[NV_W-1:0] - {rd_amp[AMP_W-1], rd_amp};
  assign nv_abs     = nv_r[NV_W-1] ? (NV_W'(0) - nv_r) : nv_r;
  assign mag        = nv_abs[MAG_W-1:0];

  assign sts.sqrt_done = (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1));
  assign sts.idx_last  = &idx_r;

  gi_ram #(
    .WIDTH (AMP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accum),
    .waddr (idx_r),
    .wdata (amp),
    .raddr (idx_r),
    .rdata (rd_amp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      idx_r    <= '0;
      total_r  <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (cmd.load_in) begin
        cnt_r <= '0;
      end else if (cmd.sqrt_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.accum) begin
        idx_r   <= idx_r + 1'b1;
        total_r <= total_r + {{QUBITS{amp[AMP_W-1]}}, amp};
      end
      if (cmd.emit_done) begin
        idx_r <= idx_r + 1'b1;
        if (sts.idx_last) begin
          total_r <= '0;
        end
      end
    end
  end

  // restoring square root, one result bit per step
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rad_r  <= {1'b0, p_sat, 16'h0000};
      rem_r  <= '0;
      root_r <= '0;
      neg_r  <= negative;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (trial >= cmp_val) begin
        rem_r  <= REM_W'(trial - cmp_val);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.calc_nv) begin
      nv_r <= nv_nxt;
    end
    if (cmd.calc_mul) begin
      prod_r <= PROD_W'(mag) * PROD_W'(mag);
    end
  end

  assign prob_full       = prod_r[PROD_W-1:16];
  assign out_probability = (prob_full > (PROD_W-16)'(ONE_Q16)) ? ONE_Q16
                         : prob_full[PROB_W-1:0];
  assign out_negative    = nv_r[NV_W-1];
  assign state_index     = SIDX_W'(idx_r);
  assign last_entry      = sts.idx_last;

endmodule

// ----- rtl/grover_iteration_core.sv -----
// input entry: an accept state, the square root iteration and a store state
// results: after the last entry the vector streams out, one result at a time, each through
//   memory read, inversion, squaring and output register; a low out_tready holds the result
// one entry in work at a time
// reset (rst_n low, synchronous): controller idle, load position and running sum zero,
//   target_index back to 5; amplitude memory contents are not cleared
module grover_iteration_core import gi_pkg::*; #(
  parameter int QUBITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [16:0] probability, [17] negative, [23:18] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [2:0] state_index, [19:3] out_probability,
                                   // [20] out_negative, [23:21] zero
  output logic        out_tlast,   // last_entry
  // target index register
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  gi_cmd_t           cmd;
  gi_sts_t           sts;
  logic [SIDX_W-1:0] state_index;
  logic [PROB_W-1:0] out_probability;
  logic              out_negative;

  // controller sequences load, root iteration, accumulate and the result sweep
  gi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  // datapath holds the amplitude memory, running sum, root unit and squarer
  gi_dp #(
    .QUBITS (QUBITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .probability     (in_tdata[16:0]),
    .negative        (in_tdata[17]),
    .state_index     (state_index),
    .out_probability (out_probability),
    .out_negative    (out_negative),
    .last_entry      (out_tlast)
  );

  // pack result fields, lowest first
  assign out_tdata = {3'b000, out_negative, out_probability, state_index};

endmodule

// ----- rtl/gi_checker.sv -----
`include "grover_iteration_core_assert.svh"

module gi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds still
  `GI_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // loading and emitting never overlap
  `GI_ASSERT_RUN(a_no_overlap, !(in_tready && out_tvalid), "input ready while a result is shown")

  // an accepted entry keeps the root unit busy
  `GI_ASSERT_RUN(a_busy_after_load, in_tvalid && in_tready |=> !in_tready, "ready right after a load")

  // the vector ends with its last transaction
  `GI_ASSERT_RUN(a_end_of_vector, out_tvalid && out_tready && out_tlast |=> !out_tvalid, "result after end of vector")

  // reset leaves no result pending
  `GI_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind grover_iteration_core gi_checker u_gi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/tb_grover_iteration_core.sv -----
`timescale 1ns / 100ps

module tb_grover_iteration_core;
  import gi_pkg::*;

  localparam int QUBITS          = 3;
  localparam int VEC_LEN         = 1 << QUBITS;
  // settle time long enough to cover an entry still in work inside the block
  localparam int SETTLE_CYCLES   = 40;
  localparam int DIR_ROWS        = 20;
  localparam int ITEMS_PER_PHASE = 110;

  // one result transaction as seen on the output stream
  typedef struct packed {
    logic [SIDX_W-1:0] idx;
    logic [PROB_W-1:0] prob;
    logic              neg;
    logic              last;
  } basis_result_t;

  // directed row; all_zero marks the last row of a vector whose results are all zero
  typedef struct packed {
    logic              all_zero;
    logic [PROB_W-1:0] prob;
    logic              neg;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [16:0] probability, [17] negative, [23:18] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [2:0] state_index, [19:3] out_probability,
                                 // [20] out_negative, [23:21] zero
  logic        out_tlast;        // last_entry
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;

  // predictor state: loaded amplitudes, load position, running sum, oracle target
  int               amp_store [VEC_LEN];
  int               load_pos = 0;
  int               amp_sum = 0;
  logic [TGT_W-1:0] oracle_target = TARGET_RESET;

  basis_result_t pending_results [$];
  basis_result_t got_result;
  basis_result_t want_result;
  stim_row_t     dir_rows [DIR_ROWS];
  logic [TGT_W-1:0] phase_target [4];

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pause_done = 1'b0;

  grover_iteration_core #(.QUBITS(QUBITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bitwise integer square root, floor of sqrt(v)
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 34;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // appends one expected result behind the ones already waiting
  task automatic queue_result(input basis_result_t r);
    pending_results = {pending_results, r};
  endtask

  // loads one entry; on the last entry of a vector computes the inverted vector
  task automatic predict_entry(input logic [PROB_W-1:0] prob, input logic neg,
                               input bit push_pred);
    longint unsigned p;
    int              amp;
    longint          twice_mean;
    longint          nv;
    longint          mag;
    longint          sq;
    basis_result_t   r;
    // probabilities above one saturate before the root
    p = (prob > ONE_Q16) ? ONE_Q16 : prob;
    amp = int'(int_sqrt(p << 16));
    if (neg) amp = -amp;
    // oracle flip decided at load time with the current target
    if (load_pos == oracle_target) amp = -amp;
    amp_store[load_pos] = amp;
    amp_sum = amp_sum + amp;
    if (load_pos != VEC_LEN - 1) begin
      load_pos = load_pos + 1;
    end else begin
      // twice the mean, rounded toward minus infinity
      twice_mean = (longint'(amp_sum) * 2) >>> QUBITS;
      for (int i = 0; i < VEC_LEN; i++) begin
        nv = twice_mean - longint'(amp_store[i]);
        mag = (nv < 0) ? -nv : nv;
        sq = (mag * mag) >>> 16;
        if (sq > longint'(ONE_Q16)) sq = longint'(ONE_Q16);
        r.idx = i[SIDX_W-1:0];
        r.prob = sq[PROB_W-1:0];
        r.neg = (nv < 0);   // exact zero counts as positive
        r.last = (i == VEC_LEN - 1);
        if (push_pred) queue_result(r);
      end
      load_pos = 0;
      amp_sum = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count = err_count + 1;
  endtask

  // one input transaction with a random gap in front of it
  task automatic send_entry(input logic [PROB_W-1:0] prob, input logic neg,
                            input bit push_pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, neg, prob};
    do @(posedge clk); while (!in_tready);
    predict_entry(prob, neg, push_pred);
  endtask

  // wait for all results, then let a partly loaded entry finish inside the block
  task automatic drain_and_settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [TGT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    oracle_target = value;
  endtask

  // mostly small probabilities, some up to one, some above one, some corner values
  function automatic logic [PROB_W-1:0] pick_probability();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return PROB_W'($urandom_range(0, 16384));
      6, 7:             return PROB_W'($urandom_range(0, 65536));
      8:                return PROB_W'($urandom_range(0, (1 << PROB_W) - 1));
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return ONE_Q16;
          2:       return PROB_W'(1);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic run_random_phase(input int n_items);
    for (int k = 0; k < n_items; k++) begin
      send_entry(pick_probability(), 1'($urandom_range(0, 1)), 1'b1);
      // once, right after a full vector: hold the input until the results are all out
      if (!pause_done && send_idle_pct == 0 && load_pos == 0 && k >= 40) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // result side: random backpressure and the scoreboard compare
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got_result.idx = out_tdata[2:0];
      got_result.prob = out_tdata[19:3];
      got_result.neg = out_tdata[20];
      got_result.last = out_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, state_index", got_result.idx, -1);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.idx !== want_result.idx)
          report_mismatch("state_index", got_result.idx, want_result.idx);
        if (got_result.prob !== want_result.prob)
          report_mismatch("out_probability", got_result.prob, want_result.prob);
        if (got_result.neg !== want_result.neg)
          report_mismatch("out_negative", got_result.neg, want_result.neg);
        if (got_result.last !== want_result.last)
          report_mismatch("last_entry", got_result.last, want_result.last);
      end
    end
  end

  initial begin
    // zero vector: every new amplitude is zero, so zero probability and positive sign
    for (int i = 0; i < VEC_LEN; i++) dir_rows[i] = '{1'b0, 17'd0, 1'b0};
    dir_rows[VEC_LEN - 1].all_zero = 1'b1;
    // extremes under the reset target: one, saturation, tiny values, negative zero
    dir_rows[8]  = '{1'b0, 17'h10000, 1'b0};
    dir_rows[9]  = '{1'b0, 17'h1ffff, 1'b1};
    dir_rows[10] = '{1'b0, 17'h10001, 1'b0};
    dir_rows[11] = '{1'b0, 17'd1,     1'b1};
    dir_rows[12] = '{1'b0, 17'd0,     1'b1};
    dir_rows[13] = '{1'b0, 17'd8192,  1'b0};   // reset target index
    dir_rows[14] = '{1'b0, 17'd43690, 1'b1};
    dir_rows[15] = '{1'b0, 17'd32768, 1'b0};
    // partial vector, finished after the target changes
    dir_rows[16] = '{1'b0, 17'd12345, 1'b1};
    dir_rows[17] = '{1'b0, 17'h10000, 1'b1};
    dir_rows[18] = '{1'b0, 17'd2,     1'b0};
    dir_rows[19] = '{1'b0, 17'h10000, 1'b0};

    phase_target[0] = 3'd0;
    phase_target[1] = 3'd7;
    phase_target[2] = 3'($urandom_range(0, 7));
    phase_target[3] = 3'd2;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset target still in place
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_entry(dir_rows[r].prob, dir_rows[r].neg, !dir_rows[r].all_zero);
      if (dir_rows[r].all_zero) begin
        for (int i = 0; i < VEC_LEN; i++)
          queue_result(basis_result_t'{i[SIDX_W-1:0], 17'd0, 1'b0, i == VEC_LEN - 1});
      end
    end
    in_tvalid <= 1'b0;
    drain_and_settle();

    // random part: new target and idle pattern per phase; all phases but phase 1 end mid-vector
    for (int ph = 0; ph < 4; ph++) begin
      write_target(phase_target[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      run_random_phase(ITEMS_PER_PHASE);
      drain_and_settle();
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gi_pkg.sv
rtl/gi_ram.sv
rtl/gi_ctrl.sv
rtl/gi_dp.sv
rtl/grover_iteration_core.sv
rtl/gi_checker.sv
tb/tb_grover_iteration_core.sv
